[rtl/rbb_pkg.sv]
// Shared types and arithmetic for the RGB 3x3 box blur.
// Used by rbb_line_buf, rgb_box_blur_3x3 and rbb_checker; no dependencies.
package rbb_pkg;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam int CFG_WIDTH = 13;
    localparam int POS_WIDTH = 12;
    localparam int SUM_WIDTH = 12;

    // Reciprocal of nine scaled by 2**16; exact after truncation for sums up to 9 * 255.
    localparam logic [12:0] RECIP_NINE = 13'd7282;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0]           red_avg;
        logic [7:0]           green_avg;
        logic [7:0]           blue_avg;
        logic [POS_WIDTH-1:0] center_col;
        logic [POS_WIDTH-1:0] center_row;
        logic                 frame_last;
    } t_pix_out;

    typedef struct packed {
        t_pix_in two_above;
        t_pix_in above;
    } t_line_pair;

    function automatic logic [7:0] div_nine(input logic [SUM_WIDTH-1:0] sum);
        logic [SUM_WIDTH+12:0] prod;
        prod = sum * RECIP_NINE;
        return prod[23:16];
    endfunction

endpackage

[rtl/rbb_line_buf.sv]
// Line buffer memory holding the two previous image rows, one entry per column.
// Depends on rbb_pkg for the entry type.
module rbb_line_buf #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    output rbb_pkg::t_line_pair o_rd_data,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  rbb_pkg::t_line_pair i_wr_data
);

    rbb_pkg::t_line_pair r_mem [DEPTH];
    rbb_pkg::t_line_pair r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/rgb_box_blur_3x3.sv]
// Top level of the streaming RGB 3x3 box blur.
// Depends on rbb_pkg and rbb_line_buf.
//
// Pixels enter in raster order on the request channel i_valid / o_ready with
// payload i_data, one pixel per accepted request. Each interior pixel yields
// one result on o_valid / i_ready with payload o_data: the truncated mean of
// its 3x3 neighborhood per channel, its column and row, and a flag on the
// last interior pixel of the frame. Border pixels give no result.
// Frame width and height are written through i_cfg_we / i_cfg_idx /
// i_cfg_data; any such write restarts the frame at column zero, row zero.
// A result passes stage A, stage B and the output register once the request
// that completes its window is accepted. One pixel is accepted every cycle while
// the input is not stalled; the line buffer memory is read when a pixel is
// accepted and written one stage later, which sets the three-stage latency.
// When the receiver stalls, the output register holds its result and the two
// stages behind it keep filling, so input stalls only once all three stages
// are full. Reset empties the pipeline, returns both counters to zero and sets
// the frame to 640 by 480.
module rgb_box_blur_3x3 #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [12:0]              i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  rbb_pkg::t_pix_in         i_data,
    output logic                     o_valid,
    input  logic                     i_ready,
    output rbb_pkg::t_pix_out        o_data
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int PW = rbb_pkg::POS_WIDTH;
    localparam int SW = rbb_pkg::SUM_WIDTH;

    logic [12:0]   r_width;
    logic [12:0]   r_height;
    logic [XW-1:0] r_col;
    logic [PW-1:0] r_row;
    logic [XW-1:0] w_last;
    logic [PW-1:0] h_last;
    logic          col_end;
    logic          row_end;
    logic          in_fire;

    logic             r_a_valid;
    rbb_pkg::t_pix_in r_a_pix;
    logic [XW-1:0]    r_a_addr;
    logic [PW-1:0]    r_a_col;
    logic [PW-1:0]    r_a_row;
    logic             r_a_emit;
    logic             r_a_last;
    logic             a_fire;

    rbb_pkg::t_line_pair rd_pair;
    rbb_pkg::t_line_pair wr_pair;
    rbb_pkg::t_pix_in    r_win [6];
    rbb_pkg::t_pix_in    taps  [9];

    logic [SW-1:0] n_sum_r;
    logic [SW-1:0] n_sum_g;
    logic [SW-1:0] n_sum_b;

    logic          r_b_valid;
    logic [SW-1:0] r_b_sum_r;
    logic [SW-1:0] r_b_sum_g;
    logic [SW-1:0] r_b_sum_b;
    logic [PW-1:0] r_b_col;
    logic [PW-1:0] r_b_row;
    logic          r_b_last;
    logic          b_fire;
    logic          b_ready;

    logic              r_c_valid;
    rbb_pkg::t_pix_out r_c_data;
    logic              c_ready;

    always_comb begin
        if (r_width < 13'd3) begin
            w_last = XW'(2);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_last = XW'(MAX_WIDTH - 1);
        end else begin
            w_last = XW'(r_width - 13'd1);
        end
        if (r_height < 13'd3) begin
            h_last = PW'(2);
        end else if (r_height > 13'd4096) begin
            h_last = {PW{1'b1}};
        end else begin
            h_last = PW'(r_height - 13'd1);
        end
    end

    assign col_end = (r_col == w_last);
    assign row_end = (r_row == h_last);

    assign c_ready = !r_c_valid || i_ready;
    assign b_ready = !r_b_valid || c_ready;
    assign o_ready = !r_a_valid || b_ready;
    assign in_fire = i_valid && o_ready;
    assign a_fire  = r_a_valid && b_ready;
    assign b_fire  = r_b_valid && c_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 13'd640;
            r_height <= 13'd480;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rbb_pkg::REG_FRAME_WIDTH: begin
                    r_width <= i_cfg_data;
                end
                rbb_pkg::REG_FRAME_HEIGHT: begin
                    r_height <= i_cfg_data;
                end
                default: begin
                    r_width <= r_width;
                end
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (in_fire) begin
            if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : r_row + PW'(1);
            end else begin
                r_col <= r_col + XW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_fire) begin
            r_a_valid <= 1'b1;
        end else if (a_fire) begin
            r_a_valid <= 1'b0;
        end
        if (in_fire) begin
            r_a_pix  <= i_data;
            r_a_addr <= r_col;
            r_a_col  <= PW'(r_col - XW'(1));
            r_a_row  <= r_row - PW'(1);
            r_a_emit <= (r_col >= XW'(2)) && (r_row >= PW'(2));
            r_a_last <= col_end && row_end;
        end
    end

    assign wr_pair.two_above = rd_pair.above;
    assign wr_pair.above     = r_a_pix;

    rbb_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (XW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (in_fire),
        .i_rd_addr (r_col),
        .o_rd_data (rd_pair),
        .i_wr_en   (a_fire),
        .i_wr_addr (r_a_addr),
        .i_wr_data (wr_pair)
    );

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            taps[i] = r_win[i];
        end
        taps[6] = rd_pair.two_above;
        taps[7] = rd_pair.above;
        taps[8] = r_a_pix;
        n_sum_r = '0;
        n_sum_g = '0;
        n_sum_b = '0;
        for (int i = 0; i < 9; i++) begin
            n_sum_r = n_sum_r + SW'(taps[i].red_in);
            n_sum_g = n_sum_g + SW'(taps[i].green_in);
            n_sum_b = n_sum_b + SW'(taps[i].blue_in);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (a_fire) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= rd_pair.two_above;
            r_win[4] <= rd_pair.above;
            r_win[5] <= r_a_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_fire) begin
            r_b_valid <= r_a_emit;
        end else if (b_fire) begin
            r_b_valid <= 1'b0;
        end
        if (a_fire) begin
            r_b_sum_r <= n_sum_r;
            r_b_sum_g <= n_sum_g;
            r_b_sum_b <= n_sum_b;
            r_b_col   <= r_a_col;
            r_b_row   <= r_a_row;
            r_b_last  <= r_a_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (b_fire) begin
            r_c_valid <= 1'b1;
        end else if (i_ready) begin
            r_c_valid <= 1'b0;
        end
        if (b_fire) begin
            r_c_data.red_avg    <= rbb_pkg::div_nine(r_b_sum_r);
            r_c_data.green_avg  <= rbb_pkg::div_nine(r_b_sum_g);
            r_c_data.blue_avg   <= rbb_pkg::div_nine(r_b_sum_b);
            r_c_data.center_col <= r_b_col;
            r_c_data.center_row <= r_b_row;
            r_c_data.frame_last <= r_b_last;
        end
    end

    assign o_valid = r_c_valid;
    assign o_data  = r_c_data;

endmodule

[rtl/rbb_checker.sv]
// Port-level checks for the RGB 3x3 box blur and the bind that attaches them.
// Depends on rbb_pkg and on the ports of rgb_box_blur_3x3.
module rbb_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input rbb_pkg::t_pix_out o_data
);

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result request present right after reset.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("Stalled result request changed or dropped.");

    a_empty_output_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("Input stalled while the output register is empty.");

    a_interior_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.center_col != '0 && o_data.center_row != '0)
        else $error("Result request for a border pixel.");

endmodule

bind rgb_box_blur_3x3 rbb_checker u_rbb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
